// ----- rtl/core/ahd_pkg.sv -----
// Shared types, constants and ramp table functions for the envelope generator.
package ahd_pkg;

   localparam int PERIOD_W  = 20;
   localparam int LEVEL_W   = 16;
   localparam int TIME_W    = 24;
   localparam int CURVE_W   = 16;
   localparam int ENV_W     = 19;
   localparam int TAB_W     = 17;
   localparam int FADE_W    = 21;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd1000000;
   localparam int                  E_FRAC_Q16   = 47073;
   localparam longint              LN2_Q30      = 64'sd744261118;

   localparam logic [1:0] SEG_ATTACK = 2'd0;
   localparam logic [1:0] SEG_HOLD   = 2'd1;
   localparam logic [1:0] SEG_DECAY  = 2'd2;
   localparam logic [1:0] SEG_DONE   = 2'd3;

   localparam logic [1:0] RD_EXP_LO = 2'd0;
   localparam logic [1:0] RD_EXP_HI = 2'd1;
   localparam logic [1:0] RD_LOG_LO = 2'd2;
   localparam logic [1:0] RD_LOG_HI = 2'd3;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       cap_en;
      logic [1:0] cap_slot;
      logic       mul_en;
      logic [1:0] mul_step;
      logic       blend_en;
      logic       blend_step;
      logic       div_init;
      logic       div_step;
      logic       update;
   } ahd_cmd_type;

   function automatic longint unsigned ahd_isqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      longint unsigned x;
      r = 64'd0;
      b = 64'd1 << 62;
      x = v;
      while (b > x) b = b >> 2;
      while (b != 64'd0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // x^e over x in [0, 1], Q.16
   function automatic logic [TAB_W-1:0] ahd_exp_entry(input int idx, input int tbits);
      longint unsigned x;
      longint unsigned acc;
      longint unsigned r;
      x   = longint'(idx) << (30 - tbits);
      acc = (x * x) >> 30;
      r   = x;
      for (int k = 1; k <= 16; k++) begin
         r = ahd_isqrt(r << 30);
         if (((E_FRAC_Q16 >> (16 - k)) & 1) != 0) acc = (acc * r) >> 30;
      end
      return TAB_W'((acc + 64'd8192) >> 14);
   endfunction

   // max(0, ln x + 1) over x in [0, 1], Q.16
   function automatic logic [TAB_W-1:0] ahd_log_entry(input int idx, input int tbits);
      int              m;
      longint unsigned y;
      longint          l2;
      longint          ln;
      longint          prod;
      m    = 0;
      y    = 64'd0;
      l2   = 64'sd0;
      ln   = 64'sd0;
      prod = 64'sd0;
      if (idx == 0) return '0;
      while ((idx >> (m + 1)) != 0) m++;
      y  = (longint'(idx) << 30) >> m;
      l2 = longint'(m - tbits) * 65536;
      for (int b = 15; b >= 0; b--) begin
         y = (y * y) >> 30;
         if (y >= (64'd1 << 31)) begin
            y  = y >> 1;
            l2 = l2 + (64'sd1 <<< b);
         end
      end
      // scale by ln 2 and drop Q.30, truncating toward zero
      prod = l2 * LN2_Q30;
      ln   = ((prod < 0) ? -((-prod) >>> 30) : (prod >>> 30)) + 64'sd65536;
      return (ln > 0) ? TAB_W'(ln) : '0;
   endfunction

endpackage

// ----- rtl/core/ahd_ramp_rom.sv -----
// Ramp table ROM: exponential and logarithmic curves with registered read.
module ahd_ramp_rom import ahd_pkg::*; #(
   parameter int TABLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic                  table_sel,
   input  logic [TABLE_BITS:0]   addr,
   output logic [TAB_W-1:0]      rd_data
);

   localparam int SIZE = (1 << TABLE_BITS) + 1;

   logic [TAB_W-1:0] exp_rom [SIZE];
   logic [TAB_W-1:0] log_rom [SIZE];
   logic [TAB_W-1:0] rd_data_ff;

   for (genvar g = 0; g < SIZE; g++) begin : g_entry
      localparam logic [TAB_W-1:0] EXP_VAL = ahd_exp_entry(g, TABLE_BITS);
      localparam logic [TAB_W-1:0] LOG_VAL = ahd_log_entry(g, TABLE_BITS);
      assign exp_rom[g] = EXP_VAL;
      assign log_rom[g] = LOG_VAL;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_sel ? log_rom[addr] : exp_rom[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ahd_datapath.sv -----
// Envelope datapath: stage state, ramp interpolation, blend, phase divider.
module ahd_datapath import ahd_pkg::*; #(
   parameter int PHASE_BITS = 24,
   parameter int TABLE_BITS = 10,
   parameter int TIME_BITS  = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ahd_cmd_type                cmd,
   input  logic                       csr_wr_en,
   input  logic [PERIOD_W-1:0]        csr_wr_data,
   input  logic signed [LEVEL_W-1:0]  req_trigger_level,
   input  logic [TIME_W-1:0]          req_attack_us,
   input  logic [TIME_W-1:0]          req_hold_us,
   input  logic [TIME_W-1:0]          req_decay_us,
   input  logic signed [CURVE_W-1:0]  req_curve_shape,
   output logic signed [ENV_W-1:0]    rsp_envelope
);

   localparam int SH  = PHASE_BITS - TABLE_BITS;
   localparam int FRW = (SH > 0) ? SH : 1;
   localparam int PW  = TAB_W + SH + 1;
   localparam int NW  = PERIOD_W + PHASE_BITS;
   localparam int DW  = TIME_BITS + 10;
   localparam int AW  = 40;

   logic [PERIOD_W-1:0]     period_ff;
   logic                    running_ff, was_high_ff;
   logic [1:0]              stage_ff;
   logic [PHASE_BITS-1:0]   phase_ff;
   logic [TIME_W-1:0]       attack_ff, hold_ff, decay_ff;
   logic signed [FADE_W-1:0] fe_ff, fl_ff;
   logic [PHASE_BITS:0]     pre_ff;
   logic [TAB_W-1:0]        tab_ff [4];
   logic [PW-1:0]           prod_ff;
   logic [TAB_W-1:0]        se_ff, sl_ff;
   logic signed [AW-1:0]    bprod_ff, acc_ff;
   logic [DW-1:0]           den_ff, rem_ff;
   logic [NW-1:0]           quo_ff;
   logic signed [ENV_W-1:0] env_ff;

   // load-time decode
   logic                     high, rise;
   logic [1:0]               stage_after;
   logic [PHASE_BITS:0]      pre_in;
   logic signed [FADE_W-1:0] c_w, fa, fai, fd, fdi, fa_raw, fai_raw;

   always_comb begin
      high        = (req_trigger_level > 0);
      rise        = high && !was_high_ff;
      stage_after = rise ? SEG_ATTACK : stage_ff;
      pre_in      = (stage_ff == SEG_DECAY)
                  ? ({1'b1, {PHASE_BITS{1'b0}}} - {1'b0, phase_ff})
                  : {1'b0, phase_ff};
      c_w     = FADE_W'(req_curve_shape);
      fa_raw  = (c_w <<< 1) - 21'sd8192;
      fai_raw = 21'sd24576 - (c_w <<< 1);
      fa  = (fa_raw < 0) ? '0 : ((fa_raw > 21'sd16384) ? 21'sd16384 : fa_raw);
      fai = (fai_raw < 0) ? '0 : ((fai_raw > 21'sd16384) ? 21'sd16384 : fai_raw);
      if (c_w >= 21'sd4096 && c_w <= 21'sd12288) begin
         fd = fai;
      end else if (c_w < 21'sd4096) begin
         fd = c_w <<< 2;
      end else begin
         fd = (c_w <<< 2) - 21'sd49152;
      end
      fdi = 21'sd16384 - fd;
   end

   // table addressing and interpolation weights
   logic [TABLE_BITS:0] idx, idx2;
   logic [FRW-1:0]      fr;
   logic [SH:0]         wt;

   assign idx  = pre_ff[PHASE_BITS:SH];
   assign idx2 = idx[TABLE_BITS] ? idx : idx + 1'b1;

   if (SH > 0) begin : g_frac
      assign fr = pre_ff[FRW-1:0];
      assign wt = {1'b1, {SH{1'b0}}} - {1'b0, fr};
   end else begin : g_nofrac
      assign fr = '0;
      assign wt = 1'b1;
   end

   logic [TAB_W-1:0] rom_data;

   ahd_ramp_rom #(.TABLE_BITS(TABLE_BITS)) u_rom (
      .clock     (clock),
      .rd_en     (cmd.rd_en),
      .table_sel (cmd.rd_sel[1]),
      .addr      (cmd.rd_sel[0] ? idx2 : idx),
      .rd_data   (rom_data)
   );

   logic [PW-1:0] prod_lo, interp_sum;
   logic [PW-1:0] prod_hi;

   always_comb begin
      prod_lo    = PW'(tab_ff[{cmd.mul_step[1], 1'b0}] * wt);
      prod_hi    = PW'(tab_ff[{cmd.mul_step[1], 1'b1}] * fr);
      interp_sum = prod_ff + prod_hi;
   end

   // blend products
   logic signed [AW-1:0] blend_e, blend_l;
   assign blend_e = AW'($signed({1'b0, se_ff}) * fe_ff);
   assign blend_l = AW'($signed({1'b0, sl_ff}) * fl_ff);

   // divider
   logic [TIME_BITS-1:0] t_raw, t_sel;
   logic [31:0]          t_ext;
   logic [DW:0]          rem_sh;
   logic                 q_bit;

   always_comb begin
      unique case (stage_ff)
         SEG_HOLD:  t_ext = 32'(hold_ff);
         SEG_DECAY: t_ext = 32'(decay_ff);
         default:   t_ext = 32'(attack_ff);
      endcase
      t_raw  = t_ext[TIME_BITS-1:0];
      t_sel  = (t_raw == '0) ? TIME_BITS'(1) : t_raw;
      rem_sh = {rem_ff, quo_ff[NW-1]};
      q_bit  = (rem_sh >= {1'b0, den_ff});
   end

   // result rounding and phase advance
   logic signed [AW-1:0]     acc_rnd;
   logic signed [ENV_W-1:0]  env_sat;
   logic [NW:0]              phase_sum;

   always_comb begin
      acc_rnd = (acc_ff + 40'sd16384) >>> 15;
      if (acc_rnd > 40'sd262143) begin
         env_sat = 19'sd262143;
      end else if (acc_rnd < -40'sd262144) begin
         env_sat = -19'sd262144;
      end else begin
         env_sat = acc_rnd[ENV_W-1:0];
      end
      phase_sum = {1'b0, quo_ff} + (NW+1)'(phase_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= PERIOD_RESET;
         running_ff  <= 1'b0;
         was_high_ff <= 1'b0;
         stage_ff    <= SEG_ATTACK;
         phase_ff    <= '0;
      end else begin
         if (csr_wr_en) period_ff <= csr_wr_data;
         if (cmd.load) begin
            was_high_ff <= high;
            if (rise) begin
               running_ff <= 1'b1;
               phase_ff   <= '0;
               stage_ff   <= SEG_ATTACK;
            end
         end
         if (cmd.update && running_ff) begin
            if (stage_ff == SEG_DONE) begin
               running_ff <= 1'b0;
            end else if (phase_sum[NW:PHASE_BITS] != '0) begin
               stage_ff <= stage_ff + 2'd1;
               phase_ff <= '0;
            end else begin
               phase_ff <= phase_sum[PHASE_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         attack_ff <= req_attack_us;
         hold_ff   <= req_hold_us;
         decay_ff  <= req_decay_us;
         pre_ff    <= pre_in;
         fe_ff     <= (stage_after == SEG_DECAY) ? fd : fai;
         fl_ff     <= (stage_after == SEG_DECAY) ? fdi : fa;
      end
      if (cmd.cap_en) tab_ff[cmd.cap_slot] <= rom_data;
      if (cmd.mul_en) begin
         if (!cmd.mul_step[0]) begin
            prod_ff <= prod_lo;
         end else if (cmd.mul_step[1]) begin
            sl_ff <= interp_sum[SH+TAB_W-1:SH];
         end else begin
            se_ff <= interp_sum[SH+TAB_W-1:SH];
         end
      end
      if (cmd.blend_en) begin
         if (!cmd.blend_step) bprod_ff <= blend_e;
         else                 acc_ff   <= bprod_ff + blend_l;
      end
      if (cmd.div_init) begin
         den_ff <= DW'(t_sel * 10'd1000);
         rem_ff <= '0;
         quo_ff <= {period_ff, {PHASE_BITS{1'b0}}};
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
         quo_ff <= {quo_ff[NW-2:0], q_bit};
      end
      if (cmd.update) begin
         if (!running_ff) begin
            env_ff <= '0;
         end else begin
            case (stage_ff)
               SEG_HOLD: env_ff <= 19'sd32768;
               SEG_DONE: env_ff <= '0;
               default:  env_ff <= env_sat;
            endcase
         end
      end
   end

   assign rsp_envelope = env_ff;

endmodule

// ----- rtl/core/ahd_controller.sv -----
// Envelope sequencer: steps the datapath through lookup, interpolation, blend, divide and update.
module ahd_controller import ahd_pkg::*; #(
   parameter int PHASE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ahd_cmd_type cmd
);

   localparam int NW = PERIOD_W + PHASE_BITS;
   localparam int CW = $clog2(NW + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_BLEND = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_WAIT  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
               cnt_in   = '0;
            end
         end
         S_READ: begin
            cmd.rd_en    = (cnt_ff < CW'(4));
            cmd.rd_sel   = cnt_ff[1:0];
            cmd.cap_en   = (cnt_ff != '0);
            cmd.cap_slot = cnt_ff[1:0] - 2'd1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(4)) begin
               state_in = S_MUL;
               cnt_in   = '0;
            end
         end
         S_MUL: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = cnt_ff[1:0];
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(3)) begin
               state_in = S_BLEND;
               cnt_in   = '0;
            end
         end
         S_BLEND: begin
            cmd.blend_en   = 1'b1;
            cmd.blend_step = cnt_ff[0];
            cmd.div_init   = !cnt_ff[0];
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff[0]) begin
               state_in = S_DIV;
               cnt_in   = '0;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NW - 1)) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (out_free) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.update || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/ahd_envelope_generator.sv -----
// Top level of the attack-hold-decay envelope generator.
//
// One request carries one audio sample: a trigger level, attack, hold and
// decay times in microseconds and a curve morph. Each request yields one
// response with the envelope sample in signed Q3.15.
// A rising trigger (not above zero, then above zero) restarts the attack.
// The sample period in ns sits in a single CSR: write it while idle.
//
// Handshake: a request is taken when req_valid is high and req_stall low. The
// sequencer then steps through table reads, interpolation, the blend, the
// bit-serial phase-increment divider and the update, after which rsp_valid
// rises. req_stall stays high from acceptance until the update, so a new
// request is taken only once the last one is through.
// The response register holds its value while rsp_stall is high; the next
// request may be taken meanwhile, and its result waits until the held
// response is taken.
// Reset (synchronous, active high) clears the envelope state, the trigger
// history and sets the sample period to 1000000 ns.
module ahd_envelope_generator import ahd_pkg::*; #(
   parameter int PHASE_BITS = 24,
   parameter int TABLE_BITS = 10,
   parameter int TIME_BITS  = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [PERIOD_W-1:0]       csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [LEVEL_W-1:0] req_trigger_level,
   input  logic [TIME_W-1:0]         req_attack_us,
   input  logic [TIME_W-1:0]         req_hold_us,
   input  logic [TIME_W-1:0]         req_decay_us,
   input  logic signed [CURVE_W-1:0] req_curve_shape,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ENV_W-1:0]   rsp_envelope
);

   ahd_cmd_type cmd;

   // sequence the request through lookup, blend, divide and update
   ahd_controller #(.PHASE_BITS(PHASE_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // hold envelope state, tables and arithmetic
   ahd_datapath #(
      .PHASE_BITS (PHASE_BITS),
      .TABLE_BITS (TABLE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_trigger_level (req_trigger_level),
      .req_attack_us     (req_attack_us),
      .req_hold_us       (req_hold_us),
      .req_decay_us      (req_decay_us),
      .req_curve_shape   (req_curve_shape),
      .rsp_envelope      (rsp_envelope)
   );

endmodule
